// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the wildcard matcher RTL.
// Needs a clock named clk and an active-high reset named rst in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define WGM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define WGM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/wgm_pkg.sv -----
// Package for the wildcard matcher: constants, register indexes and the cell link type.
// Used by wgm_cell and wildcard_glob_matcher; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package wgm_pkg;

  // Pattern storage limit and pattern characters.
  localparam int MAX_PATTERN_BYTES = 32;
  localparam logic [7:0] STAR_CHAR = 8'h2A;
  localparam logic [7:0] ANY_CHAR  = 8'h3F;

  // Configuration port layout.
  localparam int CFG_INDEX_W    = 3;
  localparam int CFG_DATA_W     = 64;
  localparam int LEN_REG_W      = 6;
  localparam int BYTES_PER_WORD = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_LENGTH     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BYTES_BASE = 3'd1;

  // What one cell hands to the next position in the same cycle.
  typedef struct packed {
    logic pre;   // position reached before the byte, after closure
    logic post;  // position reached after the byte, after closure
    logic star;  // this position holds a star inside the pattern
    logic hit;   // this position consumes the byte and reaches the next
  } link_t;

endpackage

`default_nettype wire

// ----- rtl/core/wgm_cell.sv -----
// One pattern position of the wildcard matcher: its pattern byte and its active bit.
// Depends on wgm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wgm_cell #(
  parameter int INDEX = 0,
  parameter int LW    = 6
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          pat_we,
  input  wire logic [7:0]    pat_wdata,
  input  wire logic [LW-1:0] len,
  input  wire logic [7:0]    text_byte,
  input  wire logic          has_byte,
  input  wire logic          advance,
  input  wire logic          restart,
  input  wire wgm_pkg::link_t link_in,
  output wgm_pkg::link_t     link_out,
  output logic               cur_bit
);

  localparam logic [LW-1:0] POS   = LW'(INDEX);
  localparam logic          START = (INDEX == 0);

  logic [7:0] pat;
  logic       active;
  logic       in_range;
  logic       below;
  logic       is_star;
  logic       lit_ok;
  logic       pre;
  logic       nxt;
  logic       post;

  // Pattern byte, written through the configuration port.
  always_ff @(posedge clk) begin
    if (rst) begin
      pat <= 8'h00;
    end else if (pat_we) begin
      pat <= pat_wdata;
    end
  end

  // Closure before the byte, the step over the byte and closure after it.
  always_comb begin
    in_range = (POS <= len);
    below    = (POS < len);
    is_star  = (pat == wgm_pkg::STAR_CHAR);
    lit_ok   = (pat == wgm_pkg::ANY_CHAR) || (pat == text_byte);
    pre      = in_range & (active | (link_in.pre & link_in.star));
    nxt      = (pre & is_star & below) | link_in.hit;
    post     = in_range & (nxt | (link_in.post & link_in.star));
    cur_bit  = has_byte ? post : pre;

    link_out.pre  = pre;
    link_out.post = post;
    link_out.star = is_star & below;
    link_out.hit  = pre & ~is_star & lit_ok & below;
  end

  // Active bit: takes the new set on each item, back to the start state after a name.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= START;
    end else if (advance) begin
      active <= restart ? START : cur_bit;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/wildcard_glob_matcher.sv -----
// Wildcard pattern matcher, top level: cell row, final position, registers and output buffer.
// Depends on wgm_pkg, wgm_cell and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

// Matches names, streamed one byte per item, against a pattern of up to MAX_PATTERN_BYTES
// bytes in which '*' matches any run of bytes (also none), '?' matches one byte and any
// other byte matches itself. The pattern length (register 0, clamped to MAX_PATTERN_BYTES)
// and the pattern bytes (registers 1 to 4, eight bytes each, lowest byte first) are written
// through the cfg port; the user must write them only while no name is in progress, as the
// block does not enforce this. An input item with tlast set ends the name and produces one
// result item whose bit 0 is 1 when the whole name matched; an item with has_byte clear
// carries no byte, so a lone such item with tlast is the empty name. Items may follow back
// to back while s_tready is high; the star-closure ripple runs through the cell row per item.
// A two-entry output buffer lets input continue while a result waits to be taken.
module wildcard_glob_matcher #(
  parameter int MAX_PATTERN_BYTES = wgm_pkg::MAX_PATTERN_BYTES
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // Input items.
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [7:0]                      s_tdata,   // [7:0] text_byte
  input  wire logic [0:0]                      s_tuser,   // [0] has_byte
  input  wire logic                            s_tlast,   // last_byte
  // Result items.
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [7:0]                           m_tdata,   // [0] matched, [7:1] zero
  // Configuration writes.
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [wgm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [wgm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  `include "assert_macros.svh"

  localparam int P  = MAX_PATTERN_BYTES;
  localparam int LW = $clog2(P + 1);

  logic [wgm_pkg::LEN_REG_W-1:0] len_reg;
  logic [LW-1:0]                 len;
  logic                          s_accept;
  logic                          m_pop;
  logic                          res_push;
  logic                          res_bit;
  logic [P:0]                    cur_vec;
  wgm_pkg::link_t                links [0:P];

  logic end_active;
  logic end_pre;
  logic end_post;

  logic out_valid;
  logic out_bit;
  logic skid_valid;
  logic skid_bit;
  logic out_valid_next;
  logic out_bit_next;
  logic skid_valid_next;
  logic skid_bit_next;

  assign cfg_ready = 1'b1;
  assign s_accept  = s_tvalid & s_tready;
  assign m_pop     = m_tvalid & m_tready;

  // Length register, clamped to the stored pattern size.
  always_ff @(posedge clk) begin
    if (rst) begin
      len_reg <= '0;
    end else if (cfg_valid && cfg_index == wgm_pkg::REG_LENGTH) begin
      len_reg <= cfg_data[wgm_pkg::LEN_REG_W-1:0];
    end
  end

  assign len = (len_reg > wgm_pkg::LEN_REG_W'(P)) ? LW'(P) : len_reg[LW-1:0];

  // Row of position cells; position zero sees no predecessor.
  assign links[0] = '0;

  for (genvar i = 0; i < P; i++) begin : g_cell
    localparam int WORD = i / wgm_pkg::BYTES_PER_WORD;
    localparam int LANE = i % wgm_pkg::BYTES_PER_WORD;

    logic pat_we;
    assign pat_we = cfg_valid &&
                    (cfg_index == wgm_pkg::REG_BYTES_BASE + wgm_pkg::CFG_INDEX_W'(WORD));

    wgm_cell #(
      .INDEX (i),
      .LW    (LW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .pat_we    (pat_we),
      .pat_wdata (cfg_data[LANE*8 +: 8]),
      .len       (len),
      .text_byte (s_tdata),
      .has_byte  (s_tuser[0]),
      .advance   (s_accept),
      .restart   (s_tlast),
      .link_in   (links[i]),
      .link_out  (links[i+1]),
      .cur_bit   (cur_vec[i])
    );
  end

  // Final position: reached only from its predecessor, never holds a pattern byte.
  always_comb begin
    end_pre  = (LW'(P) == len) & (end_active | (links[P].pre & links[P].star));
    end_post = (LW'(P) == len) & (links[P].hit | (links[P].post & links[P].star));
  end

  assign cur_vec[P] = s_tuser[0] ? end_post : end_pre;

  always_ff @(posedge clk) begin
    if (rst) begin
      end_active <= 1'b0;
    end else if (s_accept) begin
      end_active <= s_tlast ? 1'b0 : cur_vec[P];
    end
  end

  // The result is whether the position at the pattern length is reached.
  assign res_push = s_accept & s_tlast;
  assign res_bit  = cur_vec[len];

  // Two-entry output buffer: the output register and a skid register behind it.
  always_comb begin
    out_valid_next  = out_valid;
    out_bit_next    = out_bit;
    skid_valid_next = skid_valid;
    skid_bit_next   = skid_bit;
    if (m_pop) begin
      if (skid_valid) begin
        out_bit_next    = skid_bit;
        skid_valid_next = 1'b0;
      end else begin
        out_valid_next = 1'b0;
      end
    end
    if (res_push) begin
      if (!out_valid || m_pop) begin
        out_valid_next = 1'b1;
        out_bit_next   = res_bit;
      end else begin
        skid_valid_next = 1'b1;
        skid_bit_next   = res_bit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      out_valid  <= out_valid_next;
      skid_valid <= skid_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out_bit  <= out_bit_next;
    skid_bit <= skid_bit_next;
  end

  assign s_tready = ~skid_valid;
  assign m_tvalid = out_valid;
  assign m_tdata  = {7'b0, out_bit};

  // Checks on the output buffer and the restart after a name.
  `WGM_ASSERT(a_skid_behind_out, skid_valid |-> out_valid, "skid entry without output entry")
  `WGM_ASSERT(a_stall_fills_skid, (res_push && out_valid && !m_tready) |=> skid_valid, "result lost")
  `WGM_ASSERT(a_restart_start, res_push |=> (g_cell[0].u_cell.active && !end_active), "no restart")

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
// Self-checking testbench for wildcard_glob_matcher: directed rows, then random pattern phases.
// Depends on wgm_pkg and the wildcard_glob_matcher RTL; predicts every result internally.
`timescale 1ns / 1ps

module tb_top;

  localparam int ITEM_TARGET = 1700;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES = 300;

  // Register indexes by name.
  localparam logic [2:0] REG_LEN        = wgm_pkg::REG_LENGTH;
  localparam logic [2:0] REG_BYTES_0_7  = wgm_pkg::REG_BYTES_BASE;
  localparam logic [2:0] REG_BYTES_8_15 = wgm_pkg::REG_BYTES_BASE + 3'd1;
  localparam logic [2:0] REG_BYTES_16_23 = wgm_pkg::REG_BYTES_BASE + 3'd2;
  localparam logic [2:0] REG_BYTES_24_31 = wgm_pkg::REG_BYTES_BASE + 3'd3;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;    // [7:0] text_byte
  logic [0:0]  s_tuser;    // [0] has_byte
  logic        s_tlast;    // last_byte
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;    // [0] matched, [7:1] zero
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  // Fixed expectation travelling alongside a directed item.
  logic        typed_on;
  logic        typed_want;

  // Predictor state: pattern registers and the set of reached positions.
  logic [5:0]   pat_len_reg;
  logic [255:0] pat_store;
  logic [32:0]  reached;

  logic [7:0] verdict_q[$];
  int         fail_count;
  int         items_sent;
  bit         calm;
  bit         held_off;
  bit         hold_go;

  // Directed stimulus table.
  typedef struct {
    bit          is_cfg;
    logic [2:0]  idx;
    logic [63:0] data;
    logic [7:0]  ch;
    logic        has;
    logic        last;
    bit          typed;
    logic        want;
  } row_t;

  row_t plan[$];

  wildcard_glob_matcher DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("[wildcard_glob_matcher] ERROR");
    $finish;
  end

  function automatic logic [7:0] pat_at(input int i);
    return pat_store[8*i +: 8];
  endfunction

  function automatic logic [32:0] upto(input int n);
    logic [32:0] m;
    m = '0;
    for (int i = 0; i <= n; i++) m[i] = 1'b1;
    return m;
  endfunction

  // A reached star also reaches the position after it; ripples left to right.
  function automatic logic [32:0] star_close(input logic [32:0] set, input int n);
    for (int i = 0; i < n; i++)
      if (set[i] && pat_at(i) == wgm_pkg::STAR_CHAR) set[i+1] = 1'b1;
    return set;
  endfunction

  // Advance the reached set by one item; returns 1 when the item ends a name.
  function automatic bit match_step(input logic [7:0] ch, input logic has, input logic last,
                                    output logic hit);
    int n;
    logic [32:0] cur;
    logic [32:0] nxt;
    n = (pat_len_reg > wgm_pkg::MAX_PATTERN_BYTES) ? wgm_pkg::MAX_PATTERN_BYTES
                                                    : int'(pat_len_reg);
    cur = star_close(reached & upto(n), n);
    if (has) begin
      nxt = '0;
      for (int i = 0; i < n; i++)
        if (cur[i]) begin
          if (pat_at(i) == wgm_pkg::STAR_CHAR) nxt[i] = 1'b1;
          else if (pat_at(i) == wgm_pkg::ANY_CHAR || pat_at(i) == ch) nxt[i+1] = 1'b1;
        end
      cur = star_close(nxt & upto(n), n);
    end
    hit = cur[n];
    reached = last ? 33'd1 : (cur & upto(n));
    return last;
  endfunction

  // Monitor: check results first, then follow register writes and input items.
  always @(posedge clk) begin
    logic hit;
    logic [7:0] want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (verdict_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result item, expected none, actual %h", $time, m_tdata);
        end else begin
          want = verdict_q.pop_front();
          if (m_tdata !== want) begin
            fail_count++;
            $display("%0t: result mismatch, expected %h, actual %h", $time, want, m_tdata);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_LEN) pat_len_reg = cfg_data[5:0];
        else if (cfg_index >= REG_BYTES_0_7 && cfg_index <= REG_BYTES_24_31)
          pat_store[64*(cfg_index - REG_BYTES_0_7) +: 64] = cfg_data;
      end
      if (s_tvalid && s_tready) begin
        if (match_step(s_tdata, s_tuser[0], s_tlast, hit))
          verdict_q.insert(verdict_q.size(), {7'd0, typed_on ? typed_want : hit});
      end
    end
  end

  // Result side: random stalls, one long hold-off, and a calm stretch.
  initial begin
    m_tready = 1'b0;
    held_off = 1'b0;
    forever begin
      @(negedge clk);
      if (!held_off && hold_go) begin
        held_off = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      m_tready <= calm || ($urandom_range(99) >= 8);
    end
  end

  function automatic logic [7:0] text_char();
    int r;
    r = $urandom_range(99);
    if (r < 10) return wgm_pkg::STAR_CHAR;
    if (r < 20) return wgm_pkg::ANY_CHAR;
    if (r < 55) return 8'h61 + 8'($urandom_range(2));  // 'a' to 'c'
    return 8'($urandom_range(255));
  endfunction

  task automatic push_item(input logic [7:0] ch, input logic has, input logic last,
                           input bit typed, input logic want);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 8) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid   <= 1'b1;
    s_tdata    <= ch;
    s_tuser    <= has;
    s_tlast    <= last;
    typed_on   <= typed;
    typed_want <= want;
    do @(posedge clk); while (!s_tready);
    if (has || last) items_sent++;
  endtask

  // Stop sending and let every outstanding result and any trailing work drain.
  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic row_cfg(input logic [2:0] idx, input logic [63:0] val);
    row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.data = val;
    plan.insert(plan.size(), r);
  endtask

  task automatic row_item(input logic [7:0] ch, input logic has, input logic last,
                          input bit typed, input logic want);
    row_t r;
    r = '{default: '0};
    r.ch = ch;
    r.has = has;
    r.last = last;
    r.typed = typed;
    r.want = want;
    plan.insert(plan.size(), r);
  endtask

  // Builds a name from the current pattern, with an occasional corruption, or a random one.
  task automatic send_name(input bit near);
    logic [7:0] txt[$];
    int n;
    bit trailer;
    n = (pat_len_reg > wgm_pkg::MAX_PATTERN_BYTES) ? wgm_pkg::MAX_PATTERN_BYTES
                                                    : int'(pat_len_reg);
    if (near) begin
      for (int i = 0; i < n; i++) begin
        if (pat_at(i) == wgm_pkg::STAR_CHAR)
          repeat ($urandom_range(3)) txt.insert(txt.size(), text_char());
        else if (pat_at(i) == wgm_pkg::ANY_CHAR) txt.insert(txt.size(), text_char());
        else txt.insert(txt.size(), pat_at(i));
      end
      if ($urandom_range(99) < 30) begin
        case ($urandom_range(2))
          0: if (txt.size() > 0) txt[$urandom_range(txt.size() - 1)] = text_char();
          1: txt.insert($urandom_range(txt.size()), text_char());
          default: if (txt.size() > 0) txt.delete($urandom_range(txt.size() - 1));
        endcase
      end
    end else begin
      repeat ($urandom_range(6)) txt.insert(txt.size(), text_char());
    end
    trailer = (txt.size() == 0) || ($urandom_range(99) < 10);
    foreach (txt[j]) begin
      if ($urandom_range(99) < 5) push_item(8'($urandom_range(255)), 1'b0, 1'b0, 1'b0, 1'b0);
      push_item(txt[j], 1'b1, !trailer && j == txt.size() - 1, 1'b0, 1'b0);
    end
    if (trailer) push_item(8'($urandom_range(255)), 1'b0, 1'b1, 1'b0, 1'b0);
  endtask

  // Main sequence: reset, directed table, random pattern phases, drain and verdict.
  initial begin
    logic [255:0] pat;
    logic [5:0] plen;
    int n;
    int s;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    s_tlast = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    typed_on = 1'b0;
    typed_want = 1'b0;
    pat_len_reg = '0;
    pat_store = '0;
    reached = 33'd1;
    fail_count = 0;
    items_sent = 0;
    calm = 1'b0;
    hold_go = 1'b0;
    rst = 1'b1;

    // Empty pattern after reset: only the empty name matches.
    row_item(8'h00, 1'b0, 1'b1, 1'b1, 1'b1);
    row_item(8'h00, 1'b1, 1'b1, 1'b1, 1'b0);
    row_item(8'hA5, 1'b0, 1'b0, 1'b0, 1'b0);
    row_item(8'hFF, 1'b1, 1'b0, 1'b0, 1'b0);
    row_item(8'h00, 1'b0, 1'b1, 1'b1, 1'b0);
    // Pattern "a*?c".
    row_cfg(REG_LEN, 64'd4);
    row_cfg(REG_BYTES_0_7, 64'hFFFF_FFFF_633F_2A61);
    row_item(8'h61, 1'b1, 1'b0, 1'b0, 1'b0);
    row_item(8'h62, 1'b1, 1'b0, 1'b0, 1'b0);
    row_item(8'h63, 1'b1, 1'b1, 1'b0, 1'b0);
    row_item(8'h61, 1'b1, 1'b0, 1'b0, 1'b0);
    row_item(8'h63, 1'b1, 1'b1, 1'b0, 1'b0);
    row_item(8'h61, 1'b1, 1'b0, 1'b0, 1'b0);
    row_item(8'h78, 1'b1, 1'b0, 1'b0, 1'b0);
    row_item(8'h79, 1'b1, 1'b0, 1'b0, 1'b0);
    row_item(8'h63, 1'b1, 1'b1, 1'b0, 1'b0);
    row_item(8'h61, 1'b1, 1'b0, 1'b0, 1'b0);
    row_item(wgm_pkg::STAR_CHAR, 1'b1, 1'b0, 1'b0, 1'b0);
    row_item(wgm_pkg::ANY_CHAR, 1'b1, 1'b0, 1'b0, 1'b0);
    row_item(8'h63, 1'b1, 1'b1, 1'b0, 1'b0);
    // Oversized length is clamped; thirty-two stars match anything, the empty name too.
    row_cfg(REG_LEN, 64'd63);
    row_cfg(REG_BYTES_0_7, {8{wgm_pkg::STAR_CHAR}});
    row_cfg(REG_BYTES_8_15, {8{wgm_pkg::STAR_CHAR}});
    row_cfg(REG_BYTES_16_23, {8{wgm_pkg::STAR_CHAR}});
    row_cfg(REG_BYTES_24_31, {8{wgm_pkg::STAR_CHAR}});
    row_item(8'h00, 1'b0, 1'b1, 1'b1, 1'b1);
    row_item(8'hFF, 1'b1, 1'b1, 1'b1, 1'b1);
    // Thirty-two literal 0xFF bytes: a one-byte name falls short.
    row_cfg(REG_LEN, 64'd32);
    row_cfg(REG_BYTES_0_7, '1);
    row_cfg(REG_BYTES_8_15, '1);
    row_cfg(REG_BYTES_16_23, '1);
    row_cfg(REG_BYTES_24_31, '1);
    row_item(8'hFF, 1'b1, 1'b0, 1'b0, 1'b0);
    row_item(8'h00, 1'b0, 1'b1, 1'b1, 1'b0);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[k]) begin
      if (plan[k].is_cfg) begin
        if (k == 0 || !plan[k-1].is_cfg) wait_idle();
        write_reg(plan[k].idx, plan[k].data);
        if (k == plan.size() - 1 || !plan[k+1].is_cfg) end_writes();
      end else begin
        push_item(plan[k].ch, plan[k].has, plan[k].last, plan[k].typed, plan[k].want);
      end
    end

    // Random phases: a fresh pattern, then a batch of names against it.
    for (int phase = 0; items_sent < ITEM_TARGET; phase++) begin
      calm = (phase >= 8 && phase < 13);
      for (int k = 0; k < 8; k++) pat[32*k +: 32] = $urandom;
      if (phase == 0) begin
        plen = 6'd32;
        pat = '1;
      end else begin
        s = $urandom_range(99);
        plen = (s < 70) ? 6'($urandom_range(8)) :
               (s < 90) ? 6'($urandom_range(32, 9)) : 6'($urandom_range(63, 33));
        n = (plen > 32) ? 32 : int'(plen);
        for (int i = 0; i < n; i++) begin
          s = $urandom_range(99);
          if (s < 25) pat[8*i +: 8] = wgm_pkg::STAR_CHAR;
          else if (s < 45) pat[8*i +: 8] = wgm_pkg::ANY_CHAR;
          else if (s < 95) pat[8*i +: 8] = 8'h61 + 8'($urandom_range(2));
          else pat[8*i +: 8] = 8'($urandom_range(255));
        end
      end
      wait_idle();
      write_reg(REG_LEN, {58'd0, plen});
      write_reg(REG_BYTES_0_7, pat[63:0]);
      write_reg(REG_BYTES_8_15, pat[127:64]);
      write_reg(REG_BYTES_16_23, pat[191:128]);
      write_reg(REG_BYTES_24_31, pat[255:192]);
      end_writes();
      // The long hold-off starts with a full batch of names still to come.
      if (phase == 2) hold_go = 1'b1;
      repeat ($urandom_range(20, 4)) send_name($urandom_range(99) < 75);
    end
    calm = 1'b0;

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0)
      $display("[wildcard_glob_matcher] OK");
    else
      $display("[wildcard_glob_matcher] ERROR");
    $finish;
  end

endmodule
